>>> rtl/rqks_pkg.sv
package rqks_pkg;

  localparam int MAX_POSITIONS_DEF = 512;
  localparam int COUNTER_BITS_DEF  = 32;
  localparam int KMER_SLOTS        = 1024;
  localparam int HIST_BINS         = 128;
  localparam int LEN_BITS          = 48;
  localparam int VAL_BITS          = 48;
  localparam int OUTQ_DEPTH        = 4;

  // table select codes
  localparam logic [3:0] TBL_Q30     = 4'd0;
  localparam logic [3:0] TBL_Q20     = 4'd1;
  localparam logic [3:0] TBL_CONTENT = 4'd2;
  localparam logic [3:0] TBL_QUALSUM = 4'd3;
  localparam logic [3:0] TBL_TOTBASE = 4'd4;
  localparam logic [3:0] TBL_TOTQUAL = 4'd5;
  localparam logic [3:0] TBL_KMER    = 4'd6;
  localparam logic [3:0] TBL_HIST    = 4'd7;
  localparam logic [3:0] TBL_TOTALS  = 4'd8;

  // rows of the totals table
  localparam logic [2:0] ROW_READS  = 3'd0;
  localparam logic [2:0] ROW_LENGTH = 3'd1;
  localparam logic [2:0] ROW_OVF    = 3'd2;

  // register indexes
  localparam logic [1:0] CFG_Q20 = 2'd0;
  localparam logic [1:0] CFG_Q30 = 2'd1;
  localparam logic [1:0] CFG_OFS = 2'd2;

  localparam logic [6:0] Q20_RST = 7'd53;
  localparam logic [6:0] Q30_RST = 7'd63;
  localparam logic [6:0] OFS_RST = 7'd33;

  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_G = 8'h47;

  localparam logic [2:0] KMER_RUN = 3'd5;

  typedef struct packed {
    logic                valid;
    logic                is_read;
    logic                cls_we;
    logic                pos_we;
    logic                kmer_we;
    logic                hist_we;
    logic                q30;
    logic                q20;
    logic [6:0]          score;
    logic [3:0]          tsel;
    logic                zero;
    logic                ovf;
    logic [VAL_BITS-1:0] scalar;
  } op_t;

endpackage

>>> rtl/rqks_if.sv
interface rqks_in_if;
  import rqks_pkg::*;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] base_char;
  logic [6:0] quality_char;
  logic       last_of_read;
  logic [3:0] table_select;
  logic [2:0] row_index;
  logic [9:0] entry_index;

  modport source (output valid, func, base_char, quality_char, last_of_read,
                  table_select, row_index, entry_index, input ready);
  modport sink   (input valid, func, base_char, quality_char, last_of_read,
                  table_select, row_index, entry_index, output ready);
endinterface

interface rqks_out_if;
  import rqks_pkg::*;
  logic                valid;
  logic                ready;
  logic [VAL_BITS-1:0] read_value;
  logic                overflow_seen;

  modport source (output valid, read_value, overflow_seen, input ready);
  modport sink   (input valid, read_value, overflow_seen, output ready);
endinterface

>>> rtl/rqks_ram.sv
module rqks_ram #(
  parameter int Depth = 512,
  parameter int Width = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] wa,
  input  logic [Width-1:0]         wd,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] ra,
  output logic [Width-1:0]         rd_r
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_r <= mem[ra];
    end
  end

endmodule

>>> rtl/rqks_front.sv
module rqks_front
  import rqks_pkg::*;
#(
  parameter int MaxPos   = MAX_POSITIONS_DEF,
  parameter int WideBits = COUNTER_BITS_DEF + 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [6:0]                   cfg_wdata,
  input  logic                         acc,
  input  logic                         func,
  input  logic [7:0]                   base_char,
  input  logic [6:0]                   quality_char,
  input  logic                         last_of_read,
  input  logic [3:0]                   table_select,
  input  logic [2:0]                   row_index,
  input  logic [9:0]                   entry_index,
  output logic [$clog2(MaxPos)+2:0]    cls_ra,
  output logic [$clog2(MaxPos)-1:0]    pos_ra,
  output logic [9:0]                   kmer_ra,
  output logic [6:0]                   hist_ra,
  output logic [$clog2(MaxPos)+2:0]    cls_a_r,
  output logic [$clog2(MaxPos)-1:0]    pos_a_r,
  output logic [9:0]                   kmer_a_r,
  output logic [6:0]                   hist_a_r,
  output op_t                          op_r
);

  localparam int PA = $clog2(MaxPos);
  localparam int PW = $clog2(MaxPos + 1);
  localparam int CA = PA + 3;

  logic [6:0]          q20t_r, q30t_r, qofs_r;
  logic [PW-1:0]       pos_r, pos_nxt;
  logic [2:0]          run_r, run_nxt;
  logic [7:0]          prev_r, prev_nxt;
  logic [WideBits-1:0] reads_r, reads_nxt;
  logic [LEN_BITS-1:0] len_r, len_nxt;
  logic                ovf_r, ovf_nxt;
  op_t                 op_nxt;

  logic [PA+10:0] e_ext;
  logic           pos_ok_rd, pos_ok_acc;
  logic [2:0]     cls_sel;
  logic [PA-1:0]  p_use;
  logic           bvalid;
  logic [1:0]     bcode;
  logic [9:0]     code;
  logic [2:0]     run_inc;
  logic [6:0]     score;
  logic [VAL_BITS-1:0] scalar;
  logic           zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q20t_r <= Q20_RST;
      q30t_r <= Q30_RST;
      qofs_r <= OFS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_Q20: q20t_r <= cfg_wdata;
        CFG_Q30: q30t_r <= cfg_wdata;
        CFG_OFS: qofs_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    e_ext      = (PA + 11)'(entry_index);
    pos_ok_rd  = e_ext < (PA + 11)'(MaxPos);
    pos_ok_acc = pos_r < PW'(MaxPos);
    cls_sel    = func ? row_index : base_char[2:0];
    p_use      = func ? e_ext[PA-1:0] : pos_r[PA-1:0];
    cls_ra     = CA'(cls_sel) * CA'(MaxPos) + CA'(p_use);
    pos_ra     = p_use;

    bvalid = 1'b1;
    case (base_char)
      CH_A:    bcode = 2'd0;
      CH_T:    bcode = 2'd1;
      CH_C:    bcode = 2'd2;
      CH_G:    bcode = 2'd3;
      default: begin
        bcode  = 2'd0;
        bvalid = 1'b0;
      end
    endcase
    code    = {prev_r, bcode};
    run_inc = (run_r < KMER_RUN) ? run_r + 3'd1 : run_r;
    kmer_ra = func ? entry_index : code;
    hist_ra = func ? entry_index[6:0] : quality_char;
    score   = (quality_char >= qofs_r) ? quality_char - qofs_r : 7'd0;

    case (row_index)
      ROW_READS:  scalar = VAL_BITS'(reads_r);
      ROW_LENGTH: scalar = len_r;
      ROW_OVF:    scalar = VAL_BITS'(ovf_r);
      default:    scalar = '0;
    endcase

    case (table_select)
      TBL_Q30, TBL_Q20, TBL_CONTENT, TBL_QUALSUM, TBL_TOTBASE, TBL_TOTQUAL:
        zero = !pos_ok_rd;
      TBL_KMER:   zero = 1'b0;
      TBL_HIST:   zero = |entry_index[9:7];
      TBL_TOTALS: zero = 1'b0;
      default:    zero = 1'b1;
    endcase

    op_nxt.valid   = acc;
    op_nxt.is_read = func;
    op_nxt.cls_we  = !func && pos_ok_acc;
    op_nxt.pos_we  = !func && pos_ok_acc;
    op_nxt.kmer_we = !func && bvalid && (run_inc == KMER_RUN);
    op_nxt.hist_we = !func;
    op_nxt.q30     = quality_char >= q30t_r;
    op_nxt.q20     = (quality_char >= q30t_r) || (quality_char >= q20t_r);
    op_nxt.score   = score;
    op_nxt.tsel    = table_select;
    op_nxt.zero    = zero;
    op_nxt.ovf     = ovf_r;
    op_nxt.scalar  = scalar;

    // per-read running state, advanced by accumulate transfers only
    pos_nxt   = pos_r;
    run_nxt   = run_r;
    prev_nxt  = prev_r;
    reads_nxt = reads_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    if (acc && !func) begin
      len_nxt = (&len_r) ? len_r : len_r + 1'b1;
      if (pos_ok_acc) begin
        pos_nxt = pos_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
      if (bvalid) begin
        run_nxt  = run_inc;
        prev_nxt = code[7:0];
      end else begin
        run_nxt = '0;
      end
      if (last_of_read) begin
        reads_nxt = (&reads_r) ? reads_r : reads_r + 1'b1;
        pos_nxt   = '0;
        run_nxt   = '0;
        prev_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      run_r   <= '0;
      prev_r  <= '0;
      reads_r <= '0;
      len_r   <= '0;
      ovf_r   <= 1'b0;
      op_r    <= '0;
    end else begin
      pos_r   <= pos_nxt;
      run_r   <= run_nxt;
      prev_r  <= prev_nxt;
      reads_r <= reads_nxt;
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
      op_r    <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cls_a_r  <= cls_ra;
      pos_a_r  <= pos_ra;
      kmer_a_r <= kmer_ra;
      hist_a_r <= hist_ra;
    end
  end

endmodule

>>> rtl/rqks_back.sv
module rqks_back
  import rqks_pkg::*;
#(
  parameter int MaxPos   = MAX_POSITIONS_DEF,
  parameter int CntBits  = COUNTER_BITS_DEF,
  parameter int WideBits = COUNTER_BITS_DEF + 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  op_t                                 op,
  input  logic [$clog2(MaxPos)+2:0]           cls_a,
  input  logic [$clog2(MaxPos)-1:0]           pos_a,
  input  logic [9:0]                          kmer_a,
  input  logic [6:0]                          hist_a,
  input  logic [3*CntBits+WideBits-1:0]       cls_rd,
  input  logic [CntBits+WideBits-1:0]         pos_rd,
  input  logic [CntBits-1:0]                  kmer_rd,
  input  logic [WideBits-1:0]                 hist_rd,
  output logic                                cls_we,
  output logic [$clog2(MaxPos)+2:0]           cls_wa,
  output logic [3*CntBits+WideBits-1:0]       cls_wd,
  output logic                                pos_we,
  output logic [$clog2(MaxPos)-1:0]           pos_wa,
  output logic [CntBits+WideBits-1:0]         pos_wd,
  output logic                                kmer_we,
  output logic [9:0]                          kmer_wa,
  output logic [CntBits-1:0]                  kmer_wd,
  output logic                                hist_we,
  output logic [6:0]                          hist_wa,
  output logic [WideBits-1:0]                 hist_wd,
  output logic                                res_valid,
  output logic [VAL_BITS-1:0]                 res_value,
  output logic                                res_ovf,
  output logic                                clearing
);

  localparam int PA    = $clog2(MaxPos);
  localparam int CA    = PA + 3;
  localparam int CLS_N = 8 * MaxPos;
  localparam int CLR_N = (CLS_N > KMER_SLOTS) ? CLS_N : KMER_SLOTS;
  localparam int CW    = $clog2(CLR_N);
  localparam int CLS_W = 3 * CntBits + WideBits;
  localparam int POS_W = CntBits + WideBits;

  logic          clearing_r;
  logic [CW-1:0] clr_r;

  // last write of each memory, for a read issued in the same cycle
  logic             cf_v_r, pf_v_r, kf_v_r, hf_v_r;
  logic [CA-1:0]    cf_a_r;
  logic [PA-1:0]    pf_a_r;
  logic [9:0]       kf_a_r;
  logic [6:0]       hf_a_r;
  logic [CLS_W-1:0] cf_d_r;
  logic [POS_W-1:0] pf_d_r;
  logic [CntBits-1:0]  kf_d_r;
  logic [WideBits-1:0] hf_d_r;

  logic [CLS_W-1:0]    cls_cur, cls_new;
  logic [POS_W-1:0]    pos_cur, pos_new;
  logic [CntBits-1:0]  kmer_cur, kmer_new;
  logic [WideBits-1:0] hist_cur, hist_new;
  logic [CntBits-1:0]  c30, c20, cct, pcnt;
  logic [WideBits-1:0] cqs, pqs;
  logic [WideBits:0]   cqs_sum, pqs_sum;
  logic                acc_op;

  assign clearing = clearing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_r      <= '0;
    end else if (clearing_r) begin
      clr_r <= clr_r + 1'b1;
      if (clr_r == CW'(CLR_N - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_comb begin
    acc_op   = op.valid && !op.is_read;
    cls_cur  = (cf_v_r && cf_a_r == cls_a)  ? cf_d_r : cls_rd;
    pos_cur  = (pf_v_r && pf_a_r == pos_a)  ? pf_d_r : pos_rd;
    kmer_cur = (kf_v_r && kf_a_r == kmer_a) ? kf_d_r : kmer_rd;
    hist_cur = (hf_v_r && hf_a_r == hist_a) ? hf_d_r : hist_rd;

    {c30, c20, cct, cqs} = cls_cur;
    {pcnt, pqs}          = pos_cur;

    cqs_sum = {1'b0, cqs} + (WideBits + 1)'(op.score);
    pqs_sum = {1'b0, pqs} + (WideBits + 1)'(op.score);

    cls_new = {(op.q30 && !(&c30)) ? c30 + 1'b1 : c30,
               (op.q20 && !(&c20)) ? c20 + 1'b1 : c20,
               (&cct) ? cct : cct + 1'b1,
               cqs_sum[WideBits] ? {WideBits{1'b1}} : cqs_sum[WideBits-1:0]};
    pos_new = {(&pcnt) ? pcnt : pcnt + 1'b1,
               pqs_sum[WideBits] ? {WideBits{1'b1}} : pqs_sum[WideBits-1:0]};
    kmer_new = (&kmer_cur) ? kmer_cur : kmer_cur + 1'b1;
    hist_new = (&hist_cur) ? hist_cur : hist_cur + 1'b1;

    if (clearing_r) begin
      cls_we  = (CW + 1)'(clr_r) < (CW + 1)'(CLS_N);
      pos_we  = (CW + 1)'(clr_r) < (CW + 1)'(MaxPos);
      kmer_we = (CW + 1)'(clr_r) < (CW + 1)'(KMER_SLOTS);
      hist_we = (CW + 1)'(clr_r) < (CW + 1)'(HIST_BINS);
      cls_wa  = clr_r[CA-1:0];
      pos_wa  = clr_r[PA-1:0];
      kmer_wa = clr_r[9:0];
      hist_wa = clr_r[6:0];
      cls_wd  = '0;
      pos_wd  = '0;
      kmer_wd = '0;
      hist_wd = '0;
    end else begin
      cls_we  = acc_op && op.cls_we;
      pos_we  = acc_op && op.pos_we;
      kmer_we = acc_op && op.kmer_we;
      hist_we = acc_op && op.hist_we;
      cls_wa  = cls_a;
      pos_wa  = pos_a;
      kmer_wa = kmer_a;
      hist_wa = hist_a;
      cls_wd  = cls_new;
      pos_wd  = pos_new;
      kmer_wd = kmer_new;
      hist_wd = hist_new;
    end

    res_valid = op.valid && op.is_read;
    res_ovf   = op.ovf;
    case (op.tsel)
      TBL_Q30:     res_value = VAL_BITS'(c30);
      TBL_Q20:     res_value = VAL_BITS'(c20);
      TBL_CONTENT: res_value = VAL_BITS'(cct);
      TBL_QUALSUM: res_value = VAL_BITS'(cqs);
      TBL_TOTBASE: res_value = VAL_BITS'(pcnt);
      TBL_TOTQUAL: res_value = VAL_BITS'(pqs);
      TBL_KMER:    res_value = VAL_BITS'(kmer_cur);
      TBL_HIST:    res_value = VAL_BITS'(hist_cur);
      TBL_TOTALS:  res_value = op.scalar;
      default:     res_value = '0;
    endcase
    if (op.zero) begin
      res_value = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cf_v_r <= 1'b0;
      pf_v_r <= 1'b0;
      kf_v_r <= 1'b0;
      hf_v_r <= 1'b0;
    end else begin
      cf_v_r <= cls_we;
      pf_v_r <= pos_we;
      kf_v_r <= kmer_we;
      hf_v_r <= hist_we;
    end
  end

  always_ff @(posedge clk) begin
    cf_a_r <= cls_wa;
    cf_d_r <= cls_wd;
    pf_a_r <= pos_wa;
    pf_d_r <= pos_wd;
    kf_a_r <= kmer_wa;
    kf_d_r <= kmer_wd;
    hf_a_r <= hist_wa;
    hf_d_r <= hist_wd;
  end

endmodule

>>> rtl/rqks_outq.sv
module rqks_outq
  import rqks_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [VAL_BITS-1:0] push_value,
  input  logic                push_ovf,
  output logic [2:0]          count,
  rqks_out_if.source          out_ch
);

  localparam int AW = $clog2(OUTQ_DEPTH);

  logic [VAL_BITS:0] q_r [OUTQ_DEPTH];
  logic [AW-1:0]     wp_r, rp_r;
  logic [2:0]        cnt_r, cnt_nxt;
  logic              pop;

  assign pop                = out_ch.valid && out_ch.ready;
  assign out_ch.valid       = cnt_r != 3'd0;
  assign out_ch.read_value  = q_r[rp_r][VAL_BITS:1];
  assign out_ch.overflow_seen = q_r[rp_r][0];
  assign count              = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r + 3'(push) - 3'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= {push_value, push_ovf};
    end
  end

endmodule

>>> rtl/read_quality_kmer_stats_core.sv
// Per-cycle read quality and 5-mer statistics. Each accepted transfer on in_ch
// either adds one base (func 0) or reads one counter (func 1); only reads give
// a transfer on out_ch, in order with the bases around them. One transfer is
// taken per clock while in_ch.ready is high; its counters are read at
// acceptance, updated and written back in the cycle after, with the last
// write forwarded so that back-to-back bases at the same position or k-mer
// count correctly. Results wait in a four-entry queue, so the input keeps
// flowing while out_ch stalls until that queue is full. After reset the
// block sweeps all memories to zero, one entry a cycle, and takes no transfer
// until max(8*MAX_POSITIONS, 1024) entries (4096 by default) are swept;
// configuration writes are taken throughout. Counters saturate at all ones.
module read_quality_kmer_stats_core
  import rqks_pkg::*;
#(
  parameter int MAX_POSITIONS = MAX_POSITIONS_DEF,
  parameter int COUNTER_BITS  = COUNTER_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_wdata,
  rqks_in_if.sink    in_ch,
  rqks_out_if.source out_ch
);

  // quality sums, histogram bins and read total are 8 bits wider, capped at 48
  localparam int WIDE_BITS = (COUNTER_BITS + 8 > 48) ? 48 : COUNTER_BITS + 8;
  localparam int PA        = $clog2(MAX_POSITIONS);
  localparam int CA        = PA + 3;
  localparam int CLS_W     = 3 * COUNTER_BITS + WIDE_BITS;
  localparam int POS_W     = COUNTER_BITS + WIDE_BITS;

  logic acc;
  logic clearing;
  logic [2:0] q_count;
  logic pending;

  op_t           op_r;
  logic [CA-1:0] cls_ra, cls_a_r, cls_wa;
  logic [PA-1:0] pos_ra, pos_a_r, pos_wa;
  logic [9:0]    kmer_ra, kmer_a_r, kmer_wa;
  logic [6:0]    hist_ra, hist_a_r, hist_wa;
  logic          cls_we, pos_we, kmer_we, hist_we;
  logic [CLS_W-1:0]        cls_rd, cls_wd;
  logic [POS_W-1:0]        pos_rd, pos_wd;
  logic [COUNTER_BITS-1:0] kmer_rd, kmer_wd;
  logic [WIDE_BITS-1:0]    hist_rd, hist_wd;
  logic                    res_valid, res_ovf;
  logic [VAL_BITS-1:0]     res_value;

  // a read in the write-back stage still needs a queue slot, as does the new one
  assign pending     = op_r.valid && op_r.is_read;
  assign in_ch.ready = !clearing && ((q_count + 3'(pending)) < 3'(OUTQ_DEPTH));
  assign acc         = in_ch.valid && in_ch.ready;

  rqks_front #(
    .MaxPos   (MAX_POSITIONS),
    .WideBits (WIDE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .acc          (acc),
    .func         (in_ch.func),
    .base_char    (in_ch.base_char),
    .quality_char (in_ch.quality_char),
    .last_of_read (in_ch.last_of_read),
    .table_select (in_ch.table_select),
    .row_index    (in_ch.row_index),
    .entry_index  (in_ch.entry_index),
    .cls_ra       (cls_ra),
    .pos_ra       (pos_ra),
    .kmer_ra      (kmer_ra),
    .hist_ra      (hist_ra),
    .cls_a_r      (cls_a_r),
    .pos_a_r      (pos_a_r),
    .kmer_a_r     (kmer_a_r),
    .hist_a_r     (hist_a_r),
    .op_r         (op_r)
  );

  // per class and position: q30, q20, content and quality sum side by side
  rqks_ram #(.Depth(8 * MAX_POSITIONS), .Width(CLS_W)) u_cls_ram (
    .clk (clk), .we (cls_we), .wa (cls_wa), .wd (cls_wd),
    .re (acc), .ra (cls_ra), .rd_r (cls_rd)
  );

  // per position: base count and quality sum
  rqks_ram #(.Depth(MAX_POSITIONS), .Width(POS_W)) u_pos_ram (
    .clk (clk), .we (pos_we), .wa (pos_wa), .wd (pos_wd),
    .re (acc), .ra (pos_ra), .rd_r (pos_rd)
  );

  rqks_ram #(.Depth(KMER_SLOTS), .Width(COUNTER_BITS)) u_kmer_ram (
    .clk (clk), .we (kmer_we), .wa (kmer_wa), .wd (kmer_wd),
    .re (acc), .ra (kmer_ra), .rd_r (kmer_rd)
  );

  rqks_ram #(.Depth(HIST_BINS), .Width(WIDE_BITS)) u_hist_ram (
    .clk (clk), .we (hist_we), .wa (hist_wa), .wd (hist_wd),
    .re (acc), .ra (hist_ra), .rd_r (hist_rd)
  );

  // write-back stage, also owns the clearing sweep after reset
  rqks_back #(
    .MaxPos   (MAX_POSITIONS),
    .CntBits  (COUNTER_BITS),
    .WideBits (WIDE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op_r),
    .cls_a     (cls_a_r),
    .pos_a     (pos_a_r),
    .kmer_a    (kmer_a_r),
    .hist_a    (hist_a_r),
    .cls_rd    (cls_rd),
    .pos_rd    (pos_rd),
    .kmer_rd   (kmer_rd),
    .hist_rd   (hist_rd),
    .cls_we    (cls_we),
    .cls_wa    (cls_wa),
    .cls_wd    (cls_wd),
    .pos_we    (pos_we),
    .pos_wa    (pos_wa),
    .pos_wd    (pos_wd),
    .kmer_we   (kmer_we),
    .kmer_wa   (kmer_wa),
    .kmer_wd   (kmer_wd),
    .hist_we   (hist_we),
    .hist_wa   (hist_wa),
    .hist_wd   (hist_wd),
    .res_valid (res_valid),
    .res_value (res_value),
    .res_ovf   (res_ovf),
    .clearing  (clearing)
  );

  // result queue decouples the read path from out_ch stalls
  rqks_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_value (res_value),
    .push_ovf   (res_ovf),
    .count      (q_count),
    .out_ch     (out_ch)
  );

endmodule
